// File: hdl/dp2p_pkg.sv
// dp2p_pkg: shared constants, register map and bundle types for depth_pixel_to_point
// no dependencies
`default_nettype none

package dp2p_pkg;

  // geometry limits
  localparam int MAX_COLS_DEF = 4096;
  localparam int MAX_ROWS_DEF = 4096;

  // queue between classifier and projection pipe
  localparam int QUEUE_DEPTH = 4;

  // field widths
  localparam int DIM_W    = 13;
  localparam int INV_W    = 24;
  localparam int CENTER_W = 20;
  localparam int DEPTH_W  = 24;
  localparam int COLOR_W  = 8;
  localparam int POINT_W  = 32;
  localparam int FRAC_SH  = 16;
  localparam int SUBPIX_W = 8;

  // register map
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;
  localparam int DATA_W    = 32;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_INV_FOCAL_X  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_INV_FOCAL_Y  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_X     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Y     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DEPTH_MIN    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_DEPTH_MAX    = 3'd7;

  // reset values
  localparam logic [DIM_W-1:0]    RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0]    RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [INV_W-1:0]    RST_INV_FOCAL    = 24'd32768;
  localparam logic [CENTER_W-1:0] RST_CENTER_X     = 20'd81920;
  localparam logic [CENTER_W-1:0] RST_CENTER_Y     = 20'd61440;
  localparam logic [DEPTH_W-1:0]  RST_DEPTH_MIN    = 24'd327680;
  localparam logic [DEPTH_W-1:0]  RST_DEPTH_MAX    = 24'd655360;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [DIM_W-1:0]    image_width;
    logic [DIM_W-1:0]    image_height;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [DEPTH_W-1:0]  depth_min;
    logic [DEPTH_W-1:0]  depth_max;
  } geom_cfg_t;

  typedef struct packed {
    logic [INV_W-1:0] inv_focal_x;
    logic [INV_W-1:0] inv_focal_y;
  } focal_cfg_t;

endpackage

`default_nettype wire

// File: hdl/depth_pixel_to_point.sv
// depth_pixel_to_point: top level, register file, classifier, queue and projection pipe
// depends on dp2p_pkg, dp2p_front, dp2p_queue, dp2p_back
// Pinhole back-projection of a raster depth stream. Each input beat is one pixel (depth in
// unsigned Q8.16, mask bit, colour, first-pixel flag) and yields exactly one output beat:
// x = (u-cx)*inv_fx*z and y = (v-cy)*inv_fy*z in saturated signed Q15.16, z and colour,
// or zeros for point, z and colour with point_valid low when the depth is not strictly inside the limits.
// Sustained rate is one pixel per clock while the output is not stalled. The queue captures
// an accepted pixel at the accepting edge; it then passes through the three registered
// stages of the projection pipe (offset times reciprocal focal length, times depth,
// saturation) before its point is valid at the output. A four-entry queue lets the input
// side keep taking pixels while the output is stalled, until the queue is full.
// Configuration uses a simple register port (pready tied high, word registers at 4*i);
// write it only while no pixel is in flight.
`default_nettype none

module depth_pixel_to_point #(
  parameter int MAX_COLS = dp2p_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = dp2p_pkg::MAX_ROWS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // register port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [dp2p_pkg::ADDR_W-1:0]         paddr,
  input  wire logic [dp2p_pkg::DATA_W-1:0]         pwdata,
  output logic [dp2p_pkg::DATA_W-1:0]              prdata,
  output logic                                     pready,
  // pixel input
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [dp2p_pkg::DEPTH_W-1:0]        in_depth,
  input  wire logic                                in_masked,
  input  wire logic [dp2p_pkg::COLOR_W-1:0]        in_red_in,
  input  wire logic [dp2p_pkg::COLOR_W-1:0]        in_green_in,
  input  wire logic [dp2p_pkg::COLOR_W-1:0]        in_blue_in,
  input  wire logic                                in_first_pixel,
  // point output
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [dp2p_pkg::POINT_W-1:0]      out_point_x,
  output logic signed [dp2p_pkg::POINT_W-1:0]      out_point_y,
  output logic [dp2p_pkg::DEPTH_W-1:0]             out_point_z,
  output logic [dp2p_pkg::COLOR_W-1:0]             out_red_out,
  output logic [dp2p_pkg::COLOR_W-1:0]             out_green_out,
  output logic [dp2p_pkg::COLOR_W-1:0]             out_blue_out,
  output logic                                     out_point_valid,
  output logic                                     out_last_of_frame
);

  // offset magnitude width: widest of pixel position in Q.8 and principal point
  localparam int POS_W = ($clog2(MAX_COLS) > $clog2(MAX_ROWS)) ?
                         $clog2(MAX_COLS) : $clog2(MAX_ROWS);
  localparam int MAG_W = (POS_W + dp2p_pkg::SUBPIX_W > dp2p_pkg::CENTER_W) ?
                         POS_W + dp2p_pkg::SUBPIX_W : dp2p_pkg::CENTER_W;
  // queue entry: last, valid, rgb, z, neg_y, mag_y, neg_x, mag_x
  localparam int ENT_W = 2 * MAG_W + 2 + dp2p_pkg::DEPTH_W + 3 * dp2p_pkg::COLOR_W + 2;

  // configuration registers
  logic [dp2p_pkg::DIM_W-1:0]    image_width_r, image_height_r;
  logic [dp2p_pkg::INV_W-1:0]    inv_focal_x_r, inv_focal_y_r;
  logic [dp2p_pkg::CENTER_W-1:0] center_x_r, center_y_r;
  logic [dp2p_pkg::DEPTH_W-1:0]  depth_min_r, depth_max_r;

  logic                              wr_en;
  logic [dp2p_pkg::REG_IDX_W-1:0]    reg_idx;

  dp2p_pkg::geom_cfg_t  geom_cfg;
  dp2p_pkg::focal_cfg_t focal_cfg;
  dp2p_pkg::rgb_t       in_rgb, f_rgb, b_rgb, out_rgb;

  // front to queue
  logic                         push_valid, push_ready;
  logic [MAG_W-1:0]             f_mag_x, f_mag_y, b_mag_x, b_mag_y;
  logic                         f_neg_x, f_neg_y, b_neg_x, b_neg_y;
  logic [dp2p_pkg::DEPTH_W-1:0] f_z, b_z;
  logic                         f_ok, f_last, b_ok, b_last;
  logic [ENT_W-1:0]             push_data, pop_data;
  logic                         pop_valid, pop_ready;

  // register port: always ready, write on the access phase
  assign pready  = 1'b1;
  assign reg_idx = paddr[dp2p_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= dp2p_pkg::RST_IMAGE_WIDTH;
      image_height_r <= dp2p_pkg::RST_IMAGE_HEIGHT;
      inv_focal_x_r  <= dp2p_pkg::RST_INV_FOCAL;
      inv_focal_y_r  <= dp2p_pkg::RST_INV_FOCAL;
      center_x_r     <= dp2p_pkg::RST_CENTER_X;
      center_y_r     <= dp2p_pkg::RST_CENTER_Y;
      depth_min_r    <= dp2p_pkg::RST_DEPTH_MIN;
      depth_max_r    <= dp2p_pkg::RST_DEPTH_MAX;
    end else if (wr_en) begin
      case (reg_idx)
        dp2p_pkg::REG_IMAGE_WIDTH: begin
          image_width_r <= pwdata[dp2p_pkg::DIM_W-1:0];
        end
        dp2p_pkg::REG_IMAGE_HEIGHT: begin
          image_height_r <= pwdata[dp2p_pkg::DIM_W-1:0];
        end
        dp2p_pkg::REG_INV_FOCAL_X: begin
          inv_focal_x_r <= pwdata[dp2p_pkg::INV_W-1:0];
        end
        dp2p_pkg::REG_INV_FOCAL_Y: begin
          inv_focal_y_r <= pwdata[dp2p_pkg::INV_W-1:0];
        end
        dp2p_pkg::REG_CENTER_X: begin
          center_x_r <= pwdata[dp2p_pkg::CENTER_W-1:0];
        end
        dp2p_pkg::REG_CENTER_Y: begin
          center_y_r <= pwdata[dp2p_pkg::CENTER_W-1:0];
        end
        dp2p_pkg::REG_DEPTH_MIN: begin
          depth_min_r <= pwdata[dp2p_pkg::DEPTH_W-1:0];
        end
        dp2p_pkg::REG_DEPTH_MAX: begin
          depth_max_r <= pwdata[dp2p_pkg::DEPTH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // readback, zero-extended
  always_comb begin
    case (reg_idx)
      dp2p_pkg::REG_IMAGE_WIDTH:  prdata = dp2p_pkg::DATA_W'(image_width_r);
      dp2p_pkg::REG_IMAGE_HEIGHT: prdata = dp2p_pkg::DATA_W'(image_height_r);
      dp2p_pkg::REG_INV_FOCAL_X:  prdata = dp2p_pkg::DATA_W'(inv_focal_x_r);
      dp2p_pkg::REG_INV_FOCAL_Y:  prdata = dp2p_pkg::DATA_W'(inv_focal_y_r);
      dp2p_pkg::REG_CENTER_X:     prdata = dp2p_pkg::DATA_W'(center_x_r);
      dp2p_pkg::REG_CENTER_Y:     prdata = dp2p_pkg::DATA_W'(center_y_r);
      dp2p_pkg::REG_DEPTH_MIN:    prdata = dp2p_pkg::DATA_W'(depth_min_r);
      dp2p_pkg::REG_DEPTH_MAX:    prdata = dp2p_pkg::DATA_W'(depth_max_r);
      default:                    prdata = '0;
    endcase
  end

  assign geom_cfg.image_width  = image_width_r;
  assign geom_cfg.image_height = image_height_r;
  assign geom_cfg.center_x     = center_x_r;
  assign geom_cfg.center_y     = center_y_r;
  assign geom_cfg.depth_min    = depth_min_r;
  assign geom_cfg.depth_max    = depth_max_r;
  assign focal_cfg.inv_focal_x = inv_focal_x_r;
  assign focal_cfg.inv_focal_y = inv_focal_y_r;

  assign in_rgb.red   = in_red_in;
  assign in_rgb.green = in_green_in;
  assign in_rgb.blue  = in_blue_in;

  // classifier: counters, gate, offsets
  dp2p_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .MAG_W    (MAG_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (geom_cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_depth       (in_depth),
    .in_masked      (in_masked),
    .in_rgb         (in_rgb),
    .in_first_pixel (in_first_pixel),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .ent_mag_x      (f_mag_x),
    .ent_neg_x      (f_neg_x),
    .ent_mag_y      (f_mag_y),
    .ent_neg_y      (f_neg_y),
    .ent_z          (f_z),
    .ent_rgb        (f_rgb),
    .ent_valid      (f_ok),
    .ent_last       (f_last)
  );

  assign push_data = {f_last, f_ok, f_rgb, f_z, f_neg_y, f_mag_y, f_neg_x, f_mag_x};

  dp2p_queue #(
    .WIDTH (ENT_W),
    .DEPTH (dp2p_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign {b_last, b_ok, b_rgb, b_z, b_neg_y, b_mag_y, b_neg_x, b_mag_x} = pop_data;

  // projection pipe with output register
  dp2p_back #(
    .MAG_W (MAG_W)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (focal_cfg),
    .pop_valid         (pop_valid),
    .pop_ready         (pop_ready),
    .ent_mag_x         (b_mag_x),
    .ent_neg_x         (b_neg_x),
    .ent_mag_y         (b_mag_y),
    .ent_neg_y         (b_neg_y),
    .ent_z             (b_z),
    .ent_rgb           (b_rgb),
    .ent_valid         (b_ok),
    .ent_last          (b_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_point_x       (out_point_x),
    .out_point_y       (out_point_y),
    .out_point_z       (out_point_z),
    .out_rgb           (out_rgb),
    .out_point_valid   (out_point_valid),
    .out_last_of_frame (out_last_of_frame)
  );

  assign out_red_out   = out_rgb.red;
  assign out_green_out = out_rgb.green;
  assign out_blue_out  = out_rgb.blue;

endmodule

`default_nettype wire

// File: hdl/dp2p_queue.sv
// dp2p_queue: small register fifo between classifier and projection pipe
// depends on nothing but its parameters
`default_nettype none

module dp2p_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      count_nxt = CW'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: hdl/dp2p_front.sv
// dp2p_front: raster counters, mask and range gate, signed pixel offsets
// depends on dp2p_pkg
`default_nettype none

module dp2p_front #(
  parameter int MAX_COLS = dp2p_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = dp2p_pkg::MAX_ROWS_DEF,
  parameter int MAG_W    = 22
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire dp2p_pkg::geom_cfg_t               cfg,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [dp2p_pkg::DEPTH_W-1:0]      in_depth,
  input  wire logic                              in_masked,
  input  wire dp2p_pkg::rgb_t                    in_rgb,
  input  wire logic                              in_first_pixel,
  output logic                                   push_valid,
  input  wire logic                              push_ready,
  output logic [MAG_W-1:0]                       ent_mag_x,
  output logic                                   ent_neg_x,
  output logic [MAG_W-1:0]                       ent_mag_y,
  output logic                                   ent_neg_y,
  output logic [dp2p_pkg::DEPTH_W-1:0]           ent_z,
  output dp2p_pkg::rgb_t                         ent_rgb,
  output logic                                   ent_valid,
  output logic                                   ent_last
);

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int DC    = $clog2(MAX_COLS + 1);
  localparam int DR    = $clog2(MAX_ROWS + 1);
  localparam int DIMW0 = (DC > dp2p_pkg::DIM_W) ? DC : dp2p_pkg::DIM_W;
  localparam int DIMW  = (DR > DIMW0) ? DR : DIMW0;

  logic [CW-1:0]   col_r, col_nxt, col_cur;
  logic [RW-1:0]   row_r, row_nxt, row_cur;
  logic [DIMW-1:0] w_ext, h_ext, w_eff, h_eff;
  logic            col_end, row_end, accept, in_range;
  logic [dp2p_pkg::DEPTH_W-1:0] d;
  logic [MAG_W-1:0] px, py, cx, cy;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  // zero acts as one, oversize clamps to the maximum
  always_comb begin
    w_ext = DIMW'(cfg.image_width);
    h_ext = DIMW'(cfg.image_height);
    if (w_ext == '0) begin
      w_eff = DIMW'(1);
    end else if (w_ext > DIMW'(MAX_COLS)) begin
      w_eff = DIMW'(MAX_COLS);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext == '0) begin
      h_eff = DIMW'(1);
    end else if (h_ext > DIMW'(MAX_ROWS)) begin
      h_eff = DIMW'(MAX_ROWS);
    end else begin
      h_eff = h_ext;
    end
  end

  assign col_cur = in_first_pixel ? '0 : col_r;
  assign row_cur = in_first_pixel ? '0 : row_r;
  assign col_end = (DIMW'(col_cur) + DIMW'(1)) >= w_eff;
  assign row_end = (DIMW'(row_cur) + DIMW'(1)) >= h_eff;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : RW'(row_cur + 1'b1);
      end else begin
        col_nxt = CW'(col_cur + 1'b1);
        row_nxt = row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // range gate on masked depth
  assign d        = in_masked ? '0 : in_depth;
  assign in_range = (d > cfg.depth_min) && (d < cfg.depth_max);

  // pixel position in Q.8 against the principal point
  assign px = MAG_W'({col_cur, {dp2p_pkg::SUBPIX_W{1'b0}}});
  assign py = MAG_W'({row_cur, {dp2p_pkg::SUBPIX_W{1'b0}}});
  assign cx = MAG_W'(cfg.center_x);
  assign cy = MAG_W'(cfg.center_y);

  always_comb begin
    ent_neg_x = 1'b0;
    ent_neg_y = 1'b0;
    ent_mag_x = '0;
    ent_mag_y = '0;
    ent_z     = '0;
    ent_rgb   = '0;
    if (in_range) begin
      ent_neg_x = px < cx;
      ent_neg_y = py < cy;
      ent_mag_x = (px < cx) ? MAG_W'(cx - px) : MAG_W'(px - cx);
      ent_mag_y = (py < cy) ? MAG_W'(cy - py) : MAG_W'(py - cy);
      ent_z     = d;
      ent_rgb   = in_rgb;
    end
  end

  assign ent_valid = in_range;
  assign ent_last  = col_end && row_end;

endmodule

`default_nettype wire

// File: hdl/dp2p_back.sv
// dp2p_back: three-stage projection pipe, two rounded products per axis and saturation
// depends on dp2p_pkg
`default_nettype none

module dp2p_back #(
  parameter int MAG_W = 22
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire dp2p_pkg::focal_cfg_t              cfg,
  input  wire logic                              pop_valid,
  output logic                                   pop_ready,
  input  wire logic [MAG_W-1:0]                  ent_mag_x,
  input  wire logic                              ent_neg_x,
  input  wire logic [MAG_W-1:0]                  ent_mag_y,
  input  wire logic                              ent_neg_y,
  input  wire logic [dp2p_pkg::DEPTH_W-1:0]      ent_z,
  input  wire dp2p_pkg::rgb_t                    ent_rgb,
  input  wire logic                              ent_valid,
  input  wire logic                              ent_last,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [dp2p_pkg::POINT_W-1:0]    out_point_x,
  output logic signed [dp2p_pkg::POINT_W-1:0]    out_point_y,
  output logic [dp2p_pkg::DEPTH_W-1:0]           out_point_z,
  output dp2p_pkg::rgb_t                         out_rgb,
  output logic                                   out_point_valid,
  output logic                                   out_last_of_frame
);

  localparam int P1_W = MAG_W + dp2p_pkg::INV_W;
  localparam int T_W  = P1_W - dp2p_pkg::FRAC_SH;
  localparam int P2_W = T_W + dp2p_pkg::DEPTH_W;
  localparam int Q_W  = P2_W - dp2p_pkg::FRAC_SH;
  localparam int PW   = dp2p_pkg::POINT_W;

  // stage 1: rounded offset times reciprocal focal length
  logic                          s1_v_r;
  logic [T_W-1:0]                s1_tx_r, s1_ty_r;
  logic                          s1_nx_r, s1_ny_r;
  logic [dp2p_pkg::DEPTH_W-1:0]  s1_z_r;
  dp2p_pkg::rgb_t                s1_rgb_r;
  logic                          s1_ok_r, s1_last_r;

  // stage 2: rounded times depth
  logic                          s2_v_r;
  logic [Q_W-1:0]                s2_qx_r, s2_qy_r;
  logic                          s2_nx_r, s2_ny_r;
  logic [dp2p_pkg::DEPTH_W-1:0]  s2_z_r;
  dp2p_pkg::rgb_t                s2_rgb_r;
  logic                          s2_ok_r, s2_last_r;

  // output register
  logic                          out_v_r;
  logic [PW-1:0]                 out_x_r, out_y_r, sat_x, sat_y;
  logic [dp2p_pkg::DEPTH_W-1:0]  out_z_r;
  dp2p_pkg::rgb_t                out_rgb_r;
  logic                          out_ok_r, out_last_r;

  logic            adv;
  logic [P1_W-1:0] p1x, p1y;
  logic [P2_W-1:0] p2x, p2y;

  // whole pipe moves together unless the output beat is stalled
  assign adv       = !out_v_r || out_ready;
  assign pop_ready = adv;

  assign p1x = P1_W'(ent_mag_x) * P1_W'(cfg.inv_focal_x)
             + P1_W'(1 << (dp2p_pkg::FRAC_SH - 1));
  assign p1y = P1_W'(ent_mag_y) * P1_W'(cfg.inv_focal_y)
             + P1_W'(1 << (dp2p_pkg::FRAC_SH - 1));
  assign p2x = P2_W'(s1_tx_r) * P2_W'(s1_z_r) + P2_W'(1 << (dp2p_pkg::FRAC_SH - 1));
  assign p2y = P2_W'(s1_ty_r) * P2_W'(s1_z_r) + P2_W'(1 << (dp2p_pkg::FRAC_SH - 1));

  function automatic logic [PW-1:0] saturate(input logic [Q_W-1:0] q, input logic neg);
    logic [PW-1:0] r;
    if (neg) begin
      if (q > Q_W'(64'h8000_0000)) begin
        r = {1'b1, {(PW-1){1'b0}}};
      end else begin
        r = PW'(~q[PW-1:0] + 1'b1);
      end
    end else begin
      if (q > Q_W'(64'h7FFF_FFFF)) begin
        r = {1'b0, {(PW-1){1'b1}}};
      end else begin
        r = q[PW-1:0];
      end
    end
    return r;
  endfunction

  assign sat_x = saturate(s2_qx_r, s2_nx_r);
  assign sat_y = saturate(s2_qy_r, s2_ny_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= pop_valid;
      s2_v_r  <= s1_v_r;
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tx_r    <= p1x[P1_W-1:dp2p_pkg::FRAC_SH];
      s1_ty_r    <= p1y[P1_W-1:dp2p_pkg::FRAC_SH];
      s1_nx_r    <= ent_neg_x;
      s1_ny_r    <= ent_neg_y;
      s1_z_r     <= ent_z;
      s1_rgb_r   <= ent_rgb;
      s1_ok_r    <= ent_valid;
      s1_last_r  <= ent_last;
      s2_qx_r    <= p2x[P2_W-1:dp2p_pkg::FRAC_SH];
      s2_qy_r    <= p2y[P2_W-1:dp2p_pkg::FRAC_SH];
      s2_nx_r    <= s1_nx_r;
      s2_ny_r    <= s1_ny_r;
      s2_z_r     <= s1_z_r;
      s2_rgb_r   <= s1_rgb_r;
      s2_ok_r    <= s1_ok_r;
      s2_last_r  <= s1_last_r;
      out_x_r    <= sat_x;
      out_y_r    <= sat_y;
      out_z_r    <= s2_z_r;
      out_rgb_r  <= s2_rgb_r;
      out_ok_r   <= s2_ok_r;
      out_last_r <= s2_last_r;
    end
  end

  assign out_valid         = out_v_r;
  assign out_point_x       = out_x_r;
  assign out_point_y       = out_y_r;
  assign out_point_z       = out_z_r;
  assign out_rgb           = out_rgb_r;
  assign out_point_valid   = out_ok_r;
  assign out_last_of_frame = out_last_r;

endmodule

`default_nettype wire

// File: bench/tb_depth_pixel_to_point.sv
// tb_depth_pixel_to_point: self-checking bench for the depth pixel to 3d point projector
// depends on dp2p_pkg and depth_pixel_to_point; walks a directed pixel table, then
// random raster phases, and checks every point beat against a fixed-point projection model
`timescale 1ns / 100ps

module tb_depth_pixel_to_point;

  // cycles to let the pipe settle once nothing is pending
  localparam int DRAIN_CYCLES = 10;
  // long receiver hold-off, long enough to fill queue and pipe
  localparam int HOLD_CYCLES  = 80;
  // cycles without any accepted beat before the run is declared hung
  localparam int QUIET_LIMIT  = 4000;

  typedef enum int {
    CFG_RESET,
    CFG_NARROW,
    CFG_GATE_SHUT,
    CFG_WIDE,
    CFG_INVERTED,
    CFG_RANDOM
  } camera_set_t;

  typedef struct packed {
    logic [dp2p_pkg::DIM_W-1:0]    img_w;
    logic [dp2p_pkg::DIM_W-1:0]    img_h;
    logic [dp2p_pkg::INV_W-1:0]    inv_fx;
    logic [dp2p_pkg::INV_W-1:0]    inv_fy;
    logic [dp2p_pkg::CENTER_W-1:0] cen_x;
    logic [dp2p_pkg::CENTER_W-1:0] cen_y;
    logic [dp2p_pkg::DEPTH_W-1:0]  z_min;
    logic [dp2p_pkg::DEPTH_W-1:0]  z_max;
  } cam_cfg_t;

  typedef struct packed {
    logic [dp2p_pkg::DEPTH_W-1:0] depth;
    logic                         masked;
    logic [dp2p_pkg::COLOR_W-1:0] red;
    logic [dp2p_pkg::COLOR_W-1:0] green;
    logic [dp2p_pkg::COLOR_W-1:0] blue;
    logic                         first;
  } pixel_t;

  typedef struct packed {
    logic [dp2p_pkg::POINT_W-1:0] x;
    logic [dp2p_pkg::POINT_W-1:0] y;
    logic [dp2p_pkg::DEPTH_W-1:0] z;
    logic [dp2p_pkg::COLOR_W-1:0] red;
    logic [dp2p_pkg::COLOR_W-1:0] green;
    logic [dp2p_pkg::COLOR_W-1:0] blue;
    logic                         valid;
    logic                         last;
  } point_t;

  // one row of the directed table; want is used only when typed is set
  typedef struct packed {
    camera_set_t cam_sel;
    pixel_t      px;
    logic        typed;
    point_t      want;
  } dir_row_t;

  typedef struct packed {
    camera_set_t cam_sel;
    int          items;
    int          send_idle;
    int          recv_stall;
    logic        hold;
  } phase_t;

  localparam point_t NO_POINT      = '0;
  localparam point_t NO_POINT_LAST = '{32'h0, 32'h0, 24'h0, 8'h0, 8'h0, 8'h0, 1'b0, 1'b1};

  // fixed camera settings: width, height, 1/fx, 1/fy, cx, cy, depth min, depth max
  localparam cam_cfg_t FIXED_CFGS [5] = '{
    // power-on values
    '{dp2p_pkg::RST_IMAGE_WIDTH, dp2p_pkg::RST_IMAGE_HEIGHT,
      dp2p_pkg::RST_INV_FOCAL, dp2p_pkg::RST_INV_FOCAL,
      dp2p_pkg::RST_CENTER_X, dp2p_pkg::RST_CENTER_Y,
      dp2p_pkg::RST_DEPTH_MIN, dp2p_pkg::RST_DEPTH_MAX},
    // zero width acts as one column, full-scale x optics with zero y optics, open gate
    '{13'd0, 13'd2, 24'hff_ffff, 24'h0, 20'hf_ffff, 20'h0, 24'h0, 24'hff_ffff},
    // oversized width, zero height, gate with min equal to max
    '{13'h1fff, 13'd0, 24'd1, 24'hff_ffff, 20'h0, 20'hf_ffff, 24'h40_0000, 24'h40_0000},
    // wide rows so the column offset grows until x saturates positive
    '{13'd400, 13'd3, 24'hff_ffff, 24'hff_ffff, 20'h0, 20'hf_ffff, 24'h0, 24'hff_ffff},
    // just-over-max width, maximum height, zero optics, min above max
    '{13'd4097, 13'd4096, 24'h0, 24'h0, 20'h0, 20'h0, 24'hff_ffff, 24'h0}
  };

  // directed pixels; pixel fields are depth, masked, red, green, blue, first
  localparam dir_row_t DIRECTED_ROWS [19] = '{
    // power-on camera, 640 wide so no pixel here ends a frame
    '{CFG_RESET, '{24'h00_0000, 1'b0, 8'hff, 8'hff, 8'hff, 1'b1}, 1'b1, NO_POINT},
    '{CFG_RESET, '{24'hff_ffff, 1'b0, 8'h12, 8'h34, 8'h56, 1'b0}, 1'b1, NO_POINT},
    // depth sitting exactly on either limit is outside the open interval
    '{CFG_RESET, '{24'd327680, 1'b0, 8'hff, 8'hff, 8'hff, 1'b0}, 1'b1, NO_POINT},
    '{CFG_RESET, '{24'd655360, 1'b0, 8'hff, 8'hff, 8'hff, 1'b0}, 1'b1, NO_POINT},
    '{CFG_RESET, '{24'd327681, 1'b0, 8'hff, 8'h00, 8'hff, 1'b0}, 1'b0, NO_POINT},
    // mask wins over a good depth
    '{CFG_RESET, '{24'd500000, 1'b1, 8'hff, 8'hff, 8'hff, 1'b0}, 1'b1, NO_POINT},
    '{CFG_RESET, '{24'd655359, 1'b0, 8'h00, 8'hff, 8'h00, 1'b0}, 1'b0, NO_POINT},
    // first-pixel flag in the middle of a row resyncs the counters
    '{CFG_RESET, '{24'd458752, 1'b0, 8'h80, 8'h7f, 8'h01, 1'b1}, 1'b0, NO_POINT},
    '{CFG_RESET, '{24'd400000, 1'b0, 8'h5a, 8'ha5, 8'h3c, 1'b0}, 1'b0, NO_POINT},
    // geometry shrinks under a running counter: wraps on this pixel
    '{CFG_NARROW, '{24'h80_0000, 1'b0, 8'h11, 8'h22, 8'h33, 1'b0}, 1'b0, NO_POINT},
    // far left of a far-off center: x clamps to the most negative value
    '{CFG_NARROW, '{24'hff_fffe, 1'b0, 8'hff, 8'hff, 8'hff, 1'b1}, 1'b1,
      '{32'h8000_0000, 32'h0, 24'hff_fffe, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0}},
    '{CFG_NARROW, '{24'h00_0000, 1'b0, 8'hff, 8'hff, 8'hff, 1'b0}, 1'b1, NO_POINT_LAST},
    '{CFG_NARROW, '{24'hff_ffff, 1'b0, 8'hff, 8'hff, 8'hff, 1'b0}, 1'b1, NO_POINT},
    '{CFG_NARROW, '{24'h00_0001, 1'b0, 8'h01, 8'h02, 8'h03, 1'b0}, 1'b0, NO_POINT},
    '{CFG_NARROW, '{24'h80_0000, 1'b1, 8'hff, 8'hff, 8'hff, 1'b0}, 1'b1, NO_POINT},
    // empty gate: nothing is valid, huge clamped width keeps last low
    '{CFG_GATE_SHUT, '{24'h40_0000, 1'b0, 8'hff, 8'hff, 8'hff, 1'b0}, 1'b1, NO_POINT},
    '{CFG_GATE_SHUT, '{24'h40_0001, 1'b0, 8'hff, 8'hff, 8'hff, 1'b0}, 1'b1, NO_POINT},
    '{CFG_GATE_SHUT, '{24'h3f_ffff, 1'b0, 8'hff, 8'hff, 8'hff, 1'b0}, 1'b1, NO_POINT},
    '{CFG_GATE_SHUT, '{24'h00_0000, 1'b0, 8'hff, 8'hff, 8'hff, 1'b1}, 1'b1, NO_POINT}
  };

  // random phases: camera, pixels, sender idle %, receiver stall %, long hold-off
  localparam phase_t PHASES [8] = '{
    '{CFG_RESET,    150,  0,  0, 1'b0},
    '{CFG_RANDOM,   300, 86,  0, 1'b0},
    '{CFG_RANDOM,   300,  0, 86, 1'b0},
    '{CFG_RANDOM,   300, 25, 25, 1'b0},
    '{CFG_WIDE,     450,  0,  0, 1'b0},
    '{CFG_RANDOM,   200,  0, 25, 1'b1},
    '{CFG_INVERTED,  60, 25, 25, 1'b0},
    '{CFG_RANDOM,   140,  0,  0, 1'b0}
  };

  logic                                 clk;
  logic                                 rst_n;
  logic                                 psel;
  logic                                 penable;
  logic                                 pwrite;
  logic [dp2p_pkg::ADDR_W-1:0]          paddr;
  logic [dp2p_pkg::DATA_W-1:0]          pwdata;
  logic [dp2p_pkg::DATA_W-1:0]          prdata;
  logic                                 pready;
  logic                                 in_valid;
  logic                                 in_ready;
  logic [dp2p_pkg::DEPTH_W-1:0]         in_depth;
  logic                                 in_masked;
  logic [dp2p_pkg::COLOR_W-1:0]         in_red_in;
  logic [dp2p_pkg::COLOR_W-1:0]         in_green_in;
  logic [dp2p_pkg::COLOR_W-1:0]         in_blue_in;
  logic                                 in_first_pixel;
  logic                                 out_valid;
  logic                                 out_ready;
  logic signed [dp2p_pkg::POINT_W-1:0]  out_point_x;
  logic signed [dp2p_pkg::POINT_W-1:0]  out_point_y;
  logic [dp2p_pkg::DEPTH_W-1:0]         out_point_z;
  logic [dp2p_pkg::COLOR_W-1:0]         out_red_out;
  logic [dp2p_pkg::COLOR_W-1:0]         out_green_out;
  logic [dp2p_pkg::COLOR_W-1:0]         out_blue_out;
  logic                                 out_point_valid;
  logic                                 out_last_of_frame;

  // camera registers as the block holds them, and its raster position
  cam_cfg_t    cam;
  int unsigned raster_col;
  int unsigned raster_row;

  // points owed by the block, oldest first
  point_t      point_q[$];
  int unsigned fail_count;

  // handshake pressure knobs, set per phase
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_request;

  depth_pixel_to_point DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_depth         (in_depth),
    .in_masked        (in_masked),
    .in_red_in        (in_red_in),
    .in_green_in      (in_green_in),
    .in_blue_in       (in_blue_in),
    .in_first_pixel   (in_first_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_point_z      (out_point_z),
    .out_red_out      (out_red_out),
    .out_green_out    (out_green_out),
    .out_blue_out     (out_blue_out),
    .out_point_valid  (out_point_valid),
    .out_last_of_frame(out_last_of_frame)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // (pos - center) * inv * z as saturated signed q15.16
  // offset is q.8, each product rounded half up on the magnitude, sign put back last
  function automatic logic [dp2p_pkg::POINT_W-1:0] project_axis(
      int unsigned                   pos,
      logic [dp2p_pkg::CENTER_W-1:0] center,
      logic [dp2p_pkg::INV_W-1:0]    inv,
      logic [dp2p_pkg::DEPTH_W-1:0]  z);
    logic [63:0] pos_q8;
    logic [63:0] mag;
    logic [63:0] scaled;
    logic [63:0] prod;
    logic [63:0] negated;
    bit          neg;
    pos_q8 = 64'(pos) << dp2p_pkg::SUBPIX_W;
    neg    = pos_q8 < 64'(center);
    mag    = neg ? 64'(center) - pos_q8 : pos_q8 - 64'(center);
    scaled = (mag * 64'(inv) + 64'h8000) >> dp2p_pkg::FRAC_SH;
    prod   = (scaled * 64'(z) + 64'h8000) >> dp2p_pkg::FRAC_SH;
    if (neg) begin
      if (prod > 64'h8000_0000) prod = 64'h8000_0000;
      negated = 64'd0 - prod;
      return negated[dp2p_pkg::POINT_W-1:0];
    end
    if (prod > 64'h7fff_ffff) prod = 64'h7fff_ffff;
    return prod[dp2p_pkg::POINT_W-1:0];
  endfunction

  // point for one pixel at the current raster position; advances the raster
  function automatic point_t backproject_pixel(pixel_t px);
    point_t                       pt;
    int unsigned                  cols;
    int unsigned                  rows;
    logic [dp2p_pkg::DEPTH_W-1:0] d;
    bit                           col_end;
    bit                           row_end;
    // zero geometry acts as one, oversized as the maximum
    cols = (cam.img_w == 0) ? 1 : ((cam.img_w > dp2p_pkg::MAX_COLS_DEF) ?
                                   dp2p_pkg::MAX_COLS_DEF : cam.img_w);
    rows = (cam.img_h == 0) ? 1 : ((cam.img_h > dp2p_pkg::MAX_ROWS_DEF) ?
                                   dp2p_pkg::MAX_ROWS_DEF : cam.img_h);
    if (px.first) begin
      raster_col = 0;
      raster_row = 0;
    end
    d  = px.masked ? '0 : px.depth;
    pt = '0;
    if (d > cam.z_min && d < cam.z_max) begin
      pt.x     = project_axis(raster_col, cam.cen_x, cam.inv_fx, d);
      pt.y     = project_axis(raster_row, cam.cen_y, cam.inv_fy, d);
      pt.z     = d;
      pt.red   = px.red;
      pt.green = px.green;
      pt.blue  = px.blue;
      pt.valid = 1'b1;
    end
    // a counter past a shrunk limit counts as at the end
    col_end = raster_col >= cols - 1;
    row_end = raster_row >= rows - 1;
    pt.last = col_end && row_end;
    if (col_end) begin
      raster_col = 0;
      raster_row = row_end ? 0 : raster_row + 1;
    end else begin
      raster_col++;
    end
    return pt;
  endfunction

  // setup cycle, then access cycle; the write lands when pready is seen high
  task automatic write_reg(logic [dp2p_pkg::REG_IDX_W-1:0] idx,
                           logic [dp2p_pkg::DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_camera(cam_cfg_t c);
    write_reg(dp2p_pkg::REG_IMAGE_WIDTH,  dp2p_pkg::DATA_W'(c.img_w));
    write_reg(dp2p_pkg::REG_IMAGE_HEIGHT, dp2p_pkg::DATA_W'(c.img_h));
    write_reg(dp2p_pkg::REG_INV_FOCAL_X,  dp2p_pkg::DATA_W'(c.inv_fx));
    write_reg(dp2p_pkg::REG_INV_FOCAL_Y,  dp2p_pkg::DATA_W'(c.inv_fy));
    write_reg(dp2p_pkg::REG_CENTER_X,     dp2p_pkg::DATA_W'(c.cen_x));
    write_reg(dp2p_pkg::REG_CENTER_Y,     dp2p_pkg::DATA_W'(c.cen_y));
    write_reg(dp2p_pkg::REG_DEPTH_MIN,    dp2p_pkg::DATA_W'(c.z_min));
    write_reg(dp2p_pkg::REG_DEPTH_MAX,    dp2p_pkg::DATA_W'(c.z_max));
    cam = c;
  endtask

  // offer one pixel beat after a random gap; queue its point once accepted
  task automatic send_pixel(pixel_t px, bit typed, point_t want);
    point_t pt;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_depth       <= px.depth;
    in_masked      <= px.masked;
    in_red_in      <= px.red;
    in_green_in    <= px.green;
    in_blue_in     <= px.blue;
    in_first_pixel <= px.first;
    do @(posedge clk); while (!in_ready);
    pt = backproject_pixel(px);
    point_q.push_back(typed ? want : pt);
  endtask

  // block is idle once every owed point is out and the pipe has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (point_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [dp2p_pkg::POINT_W-1:0] want,
                             logic [dp2p_pkg::POINT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  // point sink: checks beats and drives out_ready with random stalls and one long hold
  initial begin : point_sink
    int unsigned hold_left;
    point_t      want;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready) begin
        if (point_q.size() == 0) begin
          $error("point beat with no pixel pending");
          fail_count++;
        end else begin
          want = point_q.pop_front();
          check_field("point_x", want.x, out_point_x);
          check_field("point_y", want.y, out_point_y);
          check_field("point_z", dp2p_pkg::POINT_W'(want.z),
                      dp2p_pkg::POINT_W'(out_point_z));
          check_field("red_out", dp2p_pkg::POINT_W'(want.red),
                      dp2p_pkg::POINT_W'(out_red_out));
          check_field("green_out", dp2p_pkg::POINT_W'(want.green),
                      dp2p_pkg::POINT_W'(out_green_out));
          check_field("blue_out", dp2p_pkg::POINT_W'(want.blue),
                      dp2p_pkg::POINT_W'(out_blue_out));
          check_field("point_valid", dp2p_pkg::POINT_W'(want.valid),
                      dp2p_pkg::POINT_W'(out_point_valid));
          check_field("last_of_frame", dp2p_pkg::POINT_W'(want.last),
                      dp2p_pkg::POINT_W'(out_last_of_frame));
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        // long stall while the sender keeps pushing: queue fills, in_ready drops
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
        out_ready   <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // hang detector: any accepted beat, register access or reset restarts the count
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || psel || (in_valid && in_ready) || (out_valid === 1'b1 && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    camera_set_t cur_sel;
    cam_cfg_t    rc;
    pixel_t      px;
    fail_count     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b0;
    raster_col     = 0;
    raster_row     = 0;
    cam            = FIXED_CFGS[CFG_RESET];
    cur_sel        = CFG_RESET;

    // every input known from time zero
    rst_n          <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_valid       <= 1'b0;
    in_depth       <= '0;
    in_masked      <= 1'b0;
    in_red_in      <= '0;
    in_green_in    <= '0;
    in_blue_in     <= '0;
    in_first_pixel <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, first rows on power-on registers
    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].cam_sel != cur_sel) begin
        drain();
        cur_sel = DIRECTED_ROWS[i].cam_sel;
        load_camera(FIXED_CFGS[cur_sel]);
      end
      send_pixel(DIRECTED_ROWS[i].px, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end

    // random raster phases
    foreach (PHASES[p]) begin
      drain();
      if (PHASES[p].cam_sel == CFG_RANDOM) begin
        // small frames so frame ends come often, with the odd degenerate size
        case ($urandom_range(9))
          0:       rc.img_w = '0;
          1:       rc.img_w = '1;
          default: rc.img_w = dp2p_pkg::DIM_W'($urandom_range(1, 12));
        endcase
        case ($urandom_range(9))
          0:       rc.img_h = '0;
          1:       rc.img_h = '1;
          default: rc.img_h = dp2p_pkg::DIM_W'($urandom_range(1, 6));
        endcase
        // plausible focal lengths most of the time, any 24-bit value otherwise
        rc.inv_fx = ($urandom_range(3) == 0) ? dp2p_pkg::INV_W'($urandom()) :
                                               dp2p_pkg::INV_W'($urandom_range(4000, 90000));
        rc.inv_fy = ($urandom_range(3) == 0) ? dp2p_pkg::INV_W'($urandom()) :
                                               dp2p_pkg::INV_W'($urandom_range(4000, 90000));
        rc.cen_x  = ($urandom_range(3) == 0) ? dp2p_pkg::CENTER_W'($urandom()) :
                                               dp2p_pkg::CENTER_W'($urandom_range(0, 16 * 256));
        rc.cen_y  = ($urandom_range(3) == 0) ? dp2p_pkg::CENTER_W'($urandom()) :
                                               dp2p_pkg::CENTER_W'($urandom_range(0, 8 * 256));
        rc.z_min  = dp2p_pkg::DEPTH_W'($urandom_range(0, 24'h3f_ffff));
        case ($urandom_range(5))
          0:       rc.z_max = dp2p_pkg::DEPTH_W'($urandom_range(0, rc.z_min));
          1:       rc.z_max = '1;
          default: begin
            rc.z_max = rc.z_min + dp2p_pkg::DEPTH_W'($urandom_range(2, 24'h40_0000));
          end
        endcase
        load_camera(rc);
      end else begin
        load_camera(FIXED_CFGS[PHASES[p].cam_sel]);
      end
      send_idle_pct  = PHASES[p].send_idle;
      recv_stall_pct = PHASES[p].recv_stall;
      if (PHASES[p].hold) hold_request = 1'b1;

      repeat (PHASES[p].items) begin
        // depth leans on the gate edges and the inside of the gate
        case ($urandom_range(11))
          0:       px.depth = '0;
          1:       px.depth = '1;
          2:       px.depth = cam.z_min;
          3:       px.depth = cam.z_max;
          4:       px.depth = dp2p_pkg::DEPTH_W'(cam.z_min + 1);
          5:       px.depth = dp2p_pkg::DEPTH_W'(cam.z_max - 1);
          6, 7:    px.depth = dp2p_pkg::DEPTH_W'($urandom());
          default: begin
            if (cam.z_max > cam.z_min + 1) begin
              px.depth = dp2p_pkg::DEPTH_W'($urandom_range(cam.z_min + 1, cam.z_max - 1));
            end else begin
              px.depth = dp2p_pkg::DEPTH_W'($urandom());
            end
          end
        endcase
        px.masked = ($urandom_range(9) == 0);
        px.red    = dp2p_pkg::COLOR_W'($urandom());
        px.green  = dp2p_pkg::COLOR_W'($urandom());
        px.blue   = dp2p_pkg::COLOR_W'($urandom());
        // well-formed frames mostly flag their first pixel; rare stray flags resync
        if (raster_col == 0 && raster_row == 0) begin
          px.first = ($urandom_range(9) != 0);
        end else begin
          px.first = ($urandom_range(199) == 0);
        end
        send_pixel(px, 1'b0, NO_POINT);
      end
    end

    drain();
    if (fail_count == 0 && point_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/dp2p_pkg.sv
hdl/dp2p_queue.sv
hdl/dp2p_front.sv
hdl/dp2p_back.sv
hdl/depth_pixel_to_point.sv
bench/tb_depth_pixel_to_point.sv
